### hdl/monopodial_tree_rewrite_assert.svh
// assertion macros for the checker file of the tree rewriter
`ifndef MONOPODIAL_TREE_REWRITE_ASSERT_SVH
`define MONOPODIAL_TREE_REWRITE_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define MTR_ASSERT_IMP(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) \
    else $error("tree rewriter check failed");

// next-cycle implication, disabled while dis is high
`define MTR_ASSERT_NXT(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) \
    else $error("tree rewriter check failed");

`endif

### hdl/mtr_pkg.sv
// types, constants and helpers shared by the tree rewriter files
package mtr_pkg;

  localparam int SYM_W       = 8;
  localparam int CNT_W       = 2;
  localparam int PARAM_W     = 32;
  localparam int DRAW_W      = 16;
  localparam int RATIO_W     = 17;
  localparam int ANGLE_W     = 25;
  localparam int PROD_W      = PARAM_W + RATIO_W;
  localparam int STEP_W      = 3;

  localparam int IN_W        = SYM_W + CNT_W + 2 * PARAM_W + DRAW_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = SYM_W + CNT_W + 2 * PARAM_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = ANGLE_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAJOR_RATIO   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LATERAL_RATIO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BRANCH_ANGLE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LATERAL_ANGLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIVERGENCE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_RATIO   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRE_PROB     = 3'd6;

  // register reset values
  localparam logic [RATIO_W-1:0] RST_MAJOR_RATIO   = 17'd58982;
  localparam logic [RATIO_W-1:0] RST_LATERAL_RATIO = 17'd39322;
  localparam logic [ANGLE_W-1:0] RST_BRANCH_ANGLE  = 25'd2949120;
  localparam logic [ANGLE_W-1:0] RST_LATERAL_ANGLE = 25'd2949120;
  localparam logic [ANGLE_W-1:0] RST_DIVERGENCE    = 25'd9011200;
  localparam logic [RATIO_W-1:0] RST_WIDTH_RATIO   = 17'd46334;
  localparam logic [DRAW_W-1:0]  RST_FIRE_PROB     = 16'd58982;

  // symbol codes
  localparam logic [SYM_W-1:0] SYM_A       = 8'h41;
  localparam logic [SYM_W-1:0] SYM_B       = 8'h42;
  localparam logic [SYM_W-1:0] SYM_C       = 8'h43;
  localparam logic [SYM_W-1:0] SYM_WIDTH   = 8'h21;
  localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;
  localparam logic [SYM_W-1:0] SYM_PUSH    = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_POP     = 8'h5D;
  localparam logic [SYM_W-1:0] SYM_PITCH   = 8'h26;
  localparam logic [SYM_W-1:0] SYM_ROLL    = 8'h3E;
  localparam logic [SYM_W-1:0] SYM_LEVEL   = 8'h24;
  localparam logic [SYM_W-1:0] SYM_RIGHT   = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_LEFT    = 8'h2B;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_A    = 2'd1,
    MODE_B    = 2'd2,
    MODE_C    = 2'd3
  } mode_t;

  // first member in the highest bits, so the symbol code lands lowest
  typedef struct packed {
    logic [DRAW_W-1:0]  random_draw;
    logic [PARAM_W-1:0] param_second;
    logic [PARAM_W-1:0] param_first;
    logic [CNT_W-1:0]   param_count;
    logic [SYM_W-1:0]   symbol_code;
  } in_item_t;

  typedef struct packed {
    logic [PARAM_W-1:0] out_param_second;
    logic [PARAM_W-1:0] out_param_first;
    logic [CNT_W-1:0]   out_param_count;
    logic [SYM_W-1:0]   out_symbol_code;
  } out_item_t;

  typedef struct packed {
    logic      last_of_run;
    out_item_t item;
  } result_t;

  typedef struct packed {
    mode_t              mode;
    logic [SYM_W-1:0]   sym;
    logic [CNT_W-1:0]   cnt;
    logic [PARAM_W-1:0] len;
    logic [PARAM_W-1:0] wid;
    logic [PARAM_W-1:0] len_lateral;
    logic [PARAM_W-1:0] len_major;
    logic [PARAM_W-1:0] wid_child;
  } work_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] branch_angle;
    logic [ANGLE_W-1:0] lateral_angle;
    logic [ANGLE_W-1:0] divergence_angle;
  } angles_t;

  // truncating q16.16 by q1.16 scale, saturating at the top of 32 bits
  function automatic logic [PARAM_W-1:0] scale_q(input logic [PARAM_W-1:0] p,
                                                 input logic [RATIO_W-1:0] r);
    logic [PROD_W-1:0] prod;
    prod = {{RATIO_W{1'b0}}, p} * {{PARAM_W{1'b0}}, r};
    if (prod[PROD_W-1]) begin
      return {PARAM_W{1'b1}};
    end
    return prod[PROD_W-2:16];
  endfunction

  function automatic logic [PARAM_W-1:0] angle_param(input logic [ANGLE_W-1:0] a);
    return {{(PARAM_W - ANGLE_W){1'b0}}, a};
  endfunction

endpackage

### hdl/mtr_expand.sv
// picks the result for one step of a rewritten or passed-through symbol
module mtr_expand (
  input  mtr_pkg::work_t                  work,
  input  logic [mtr_pkg::STEP_W-1:0]      step,
  input  mtr_pkg::angles_t                angles,
  output mtr_pkg::result_t                res
);
  import mtr_pkg::*;

  logic [SYM_W-1:0] turn_sym;
  logic [SYM_W-1:0] child_sym;

  function automatic result_t mk(input logic [SYM_W-1:0] s, input logic [CNT_W-1:0] c,
                                 input logic [PARAM_W-1:0] p1,
                                 input logic [PARAM_W-1:0] p2, input logic last);
    result_t r;
    r.last_of_run           = last;
    r.item.out_symbol_code  = s;
    r.item.out_param_count  = c;
    r.item.out_param_first  = p1;
    r.item.out_param_second = p2;
    return r;
  endfunction

  assign turn_sym  = (work.mode == MODE_B) ? SYM_RIGHT : SYM_LEFT;
  assign child_sym = (work.mode == MODE_B) ? SYM_C : SYM_B;

  always_comb begin
    res = mk(work.sym, work.cnt, work.len, work.wid, 1'b1);
    if (work.mode != MODE_PASS) begin
      case (step)
        3'd0: res = mk(SYM_WIDTH, CNT_ONE, work.wid, '0, 1'b0);
        3'd1: res = mk(SYM_FORWARD, CNT_ONE, work.len, '0, 1'b0);
        3'd2: res = mk(SYM_PUSH, CNT_NONE, '0, '0, 1'b0);
        3'd3: begin
          if (work.mode == MODE_A) begin
            res = mk(SYM_PITCH, CNT_ONE, angle_param(angles.branch_angle), '0, 1'b0);
          end else begin
            res = mk(turn_sym, CNT_ONE, angle_param(angles.lateral_angle), '0, 1'b0);
          end
        end
        3'd4: begin
          if (work.mode == MODE_A) begin
            res = mk(SYM_B, CNT_TWO, work.len_lateral, work.wid_child, 1'b0);
          end else begin
            res = mk(SYM_LEVEL, CNT_NONE, '0, '0, 1'b0);
          end
        end
        3'd5: begin
          if (work.mode == MODE_A) begin
            res = mk(SYM_POP, CNT_NONE, '0, '0, 1'b0);
          end else begin
            res = mk(child_sym, CNT_TWO, work.len_lateral, work.wid_child, 1'b0);
          end
        end
        3'd6: begin
          if (work.mode == MODE_A) begin
            res = mk(SYM_ROLL, CNT_ONE, angle_param(angles.divergence_angle), '0, 1'b0);
          end else begin
            res = mk(SYM_POP, CNT_NONE, '0, '0, 1'b0);
          end
        end
        3'd7: begin
          if (work.mode == MODE_A) begin
            res = mk(SYM_A, CNT_TWO, work.len_major, work.wid_child, 1'b1);
          end else begin
            res = mk(child_sym, CNT_TWO, work.len_major, work.wid_child, 1'b1);
          end
        end
        default: res = mk(work.sym, work.cnt, work.len, work.wid, 1'b1);
      endcase
    end
  end

endmodule

### hdl/monopodial_tree_rewrite.sv
// Rewrites one parametric symbol per input transaction under a monopodial tree grammar.
// An item passes an input register, a scaling stage (three 32x17 multiplies, registered)
// and an output register, in that order.
// Symbols that pass through stream at one per cycle while the output is not stalled;
// a rewritten A, B or C holds the scaling stage while its eight results leave one per
// cycle through the output register, unless stalled, and the next item waits in the
// input register. Configuration writes are always ready and take effect next cycle.
module monopodial_tree_rewrite (
  input  logic                                clk,
  input  logic                                rst,
  // symbol_code, param_count, param_first, param_second, random_draw
  input  logic [mtr_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // out_symbol_code, out_param_count, out_param_first, out_param_second
  output logic [mtr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mtr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mtr_pkg::*;

  logic [RATIO_W-1:0] major_ratio;
  logic [RATIO_W-1:0] lateral_ratio;
  logic [RATIO_W-1:0] width_ratio;
  logic [DRAW_W-1:0]  fire_prob;
  angles_t            angles;

  logic               in_valid;
  in_item_t           in_item;
  logic               work_valid;
  work_t              work;
  logic [STEP_W-1:0]  step;
  logic               out_valid;
  result_t            out_res;

  work_t              work_next;
  result_t            res;
  logic               out_load;
  logic               emit;
  logic               work_done;
  logic               in_move;
  logic               is_abc;
  logic               fire;
  logic [PARAM_W-1:0] len_in;
  logic [PARAM_W-1:0] wid_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_ratio             <= RST_MAJOR_RATIO;
      lateral_ratio           <= RST_LATERAL_RATIO;
      angles.branch_angle     <= RST_BRANCH_ANGLE;
      angles.lateral_angle    <= RST_LATERAL_ANGLE;
      angles.divergence_angle <= RST_DIVERGENCE;
      width_ratio             <= RST_WIDTH_RATIO;
      fire_prob               <= RST_FIRE_PROB;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAJOR_RATIO:   major_ratio             <= cfg_data[RATIO_W-1:0];
        REG_LATERAL_RATIO: lateral_ratio           <= cfg_data[RATIO_W-1:0];
        REG_BRANCH_ANGLE:  angles.branch_angle     <= cfg_data[ANGLE_W-1:0];
        REG_LATERAL_ANGLE: angles.lateral_angle    <= cfg_data[ANGLE_W-1:0];
        REG_DIVERGENCE:    angles.divergence_angle <= cfg_data[ANGLE_W-1:0];
        REG_WIDTH_RATIO:   width_ratio             <= cfg_data[RATIO_W-1:0];
        REG_FIRE_PROB:     fire_prob               <= cfg_data[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain: output register, then scaling stage, then input register
  assign out_load  = !out_valid || m_tready;
  assign emit      = work_valid && out_load;
  assign work_done = emit && res.last_of_run;
  assign in_move   = in_valid && (!work_valid || work_done);
  assign s_tready  = !in_valid || in_move;

  // missing parameters read as zero
  assign len_in = (in_item.param_count >= CNT_ONE) ? in_item.param_first : '0;
  assign wid_in = (in_item.param_count >= CNT_TWO) ? in_item.param_second : '0;
  assign is_abc = (in_item.symbol_code == SYM_A) || (in_item.symbol_code == SYM_B) ||
                  (in_item.symbol_code == SYM_C);
  assign fire   = is_abc && (in_item.random_draw <= fire_prob);

  always_comb begin
    work_next.sym         = in_item.symbol_code;
    work_next.cnt         = in_item.param_count;
    work_next.len         = len_in;
    work_next.wid         = wid_in;
    work_next.len_lateral = scale_q(len_in, lateral_ratio);
    work_next.len_major   = scale_q(len_in, major_ratio);
    work_next.wid_child   = scale_q(wid_in, width_ratio);
    if (!fire) begin
      work_next.mode = MODE_PASS;
    end else if (in_item.symbol_code == SYM_A) begin
      work_next.mode = MODE_A;
    end else if (in_item.symbol_code == SYM_B) begin
      work_next.mode = MODE_B;
    end else begin
      work_next.mode = MODE_C;
    end
  end

  mtr_expand u_expand (
    .work   (work),
    .step   (step),
    .angles (angles),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      work_valid <= 1'b0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (in_move) begin
        in_valid <= 1'b0;
      end
      if (in_move) begin
        work_valid <= 1'b1;
        step       <= '0;
      end else if (work_done) begin
        work_valid <= 1'b0;
      end else if (emit) begin
        step <= step + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[IN_W-1:0];
    end
    if (in_move) begin
      work <= work_next;
    end
    if (emit) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.last_of_run;
  assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_res.item};

endmodule

### hdl/mtr_checker.sv
// port-level checks for the tree rewriter, bound to the top level
`include "monopodial_tree_rewrite_assert.svh"

module mtr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic                            m_tlast,
  input logic [mtr_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mtr_pkg::*;

  out_item_t shown;

  assign shown = m_tdata[OUT_W-1:0];

  // a stalled result transaction keeps its content
  `MTR_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // parameters beyond the count are zero
  `MTR_ASSERT_IMP(a_unused_zero, clk, rst, m_tvalid && (shown.out_param_count == CNT_NONE), (shown.out_param_first == '0) && (shown.out_param_second == '0))
  `MTR_ASSERT_IMP(a_second_zero, clk, rst, m_tvalid && (shown.out_param_count == CNT_ONE), shown.out_param_second == '0)
  // input back-pressure only while a result is on its way
  `MTR_ASSERT_NXT(a_stall_has_work, clk, rst, !s_tready, m_tvalid)
  // nothing offered straight after reset
  `MTR_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

endmodule

bind monopodial_tree_rewrite mtr_checker u_checker (.*);

### tb/monopodial_tree_rewrite_test.sv
// self-checking stream testbench for the monopodial tree rewriter
module monopodial_tree_rewrite_test;
  import mtr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP = 60;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [SYM_W-1:0] SYM_LOWER_A = 8'h61;
  localparam logic [SYM_W-1:0] SYM_LOWER_X = 8'h78;
  // a count of three keeps both parameters
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_TWO | CNT_ONE;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_TDATA_W-1:0] s_tdata = '0;   // symbol_code, param_count, param_first,
                                          // param_second, random_draw
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;        // out_symbol_code, out_param_count,
                                          // out_param_first, out_param_second
  logic m_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MAJOR_RATIO;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies used for prediction
  logic [RATIO_W-1:0] major_ratio = RST_MAJOR_RATIO;
  logic [RATIO_W-1:0] lateral_ratio = RST_LATERAL_RATIO;
  logic [ANGLE_W-1:0] branch_deg = RST_BRANCH_ANGLE;
  logic [ANGLE_W-1:0] lateral_deg = RST_LATERAL_ANGLE;
  logic [ANGLE_W-1:0] divergence_deg = RST_DIVERGENCE;
  logic [RATIO_W-1:0] width_ratio = RST_WIDTH_RATIO;
  logic [DRAW_W-1:0] fire_threshold = RST_FIRE_PROB;

  in_item_t pending_symbols[$];
  result_t results_due[$];
  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int src_hold = 0;
  int sink_hold = 0;
  int unsigned cycle_count = 0;
  out_item_t seen;
  result_t due;

  monopodial_tree_rewrite u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // append one symbol to the source queue
  task automatic add_symbol(input in_item_t it);
    pending_symbols = {pending_symbols, it};
  endtask

  // truncating q16.16 by q1.16 product, clamped to 32 bits
  function automatic logic [PARAM_W-1:0] apply_ratio(input logic [PARAM_W-1:0] p,
                                                     input logic [RATIO_W-1:0] r);
    logic [63:0] full;
    full = (64'(p) * 64'(r)) >> 16;
    return (full > 64'hFFFF_FFFF) ? '1 : full[PARAM_W-1:0];
  endfunction

  task automatic queue_result(input logic [SYM_W-1:0] sym, input logic [CNT_W-1:0] cnt,
                              input logic [PARAM_W-1:0] first,
                              input logic [PARAM_W-1:0] second, input logic last);
    result_t r;
    r.item.out_symbol_code = sym;
    r.item.out_param_count = cnt;
    r.item.out_param_first = first;
    r.item.out_param_second = second;
    r.last_of_run = last;
    results_due = {results_due, r};
  endtask

  task automatic predict_rewrite(input in_item_t it);
    logic [PARAM_W-1:0] len, wid, len_lat, len_maj, wid_child;
    logic [SYM_W-1:0] turn, child;
    len = (it.param_count >= CNT_ONE) ? it.param_first : '0;
    wid = (it.param_count >= CNT_TWO) ? it.param_second : '0;
    if (!(it.symbol_code inside {SYM_A, SYM_B, SYM_C}) || it.random_draw > fire_threshold)
    begin
      queue_result(it.symbol_code, it.param_count, len, wid, 1'b1);
      return;
    end
    len_lat = apply_ratio(len, lateral_ratio);
    len_maj = apply_ratio(len, major_ratio);
    wid_child = apply_ratio(wid, width_ratio);
    queue_result(SYM_WIDTH, CNT_ONE, wid, '0, 1'b0);
    queue_result(SYM_FORWARD, CNT_ONE, len, '0, 1'b0);
    queue_result(SYM_PUSH, CNT_NONE, '0, '0, 1'b0);
    if (it.symbol_code == SYM_A) begin
      queue_result(SYM_PITCH, CNT_ONE, PARAM_W'(branch_deg), '0, 1'b0);
      queue_result(SYM_B, CNT_TWO, len_lat, wid_child, 1'b0);
      queue_result(SYM_POP, CNT_NONE, '0, '0, 1'b0);
      queue_result(SYM_ROLL, CNT_ONE, PARAM_W'(divergence_deg), '0, 1'b0);
      queue_result(SYM_A, CNT_TWO, len_maj, wid_child, 1'b1);
    end else begin
      turn = (it.symbol_code == SYM_B) ? SYM_RIGHT : SYM_LEFT;
      child = (it.symbol_code == SYM_B) ? SYM_C : SYM_B;
      queue_result(turn, CNT_ONE, PARAM_W'(lateral_deg), '0, 1'b0);
      queue_result(SYM_LEVEL, CNT_NONE, '0, '0, 1'b0);
      queue_result(child, CNT_TWO, len_lat, wid_child, 1'b0);
      queue_result(SYM_POP, CNT_NONE, '0, '0, 1'b0);
      queue_result(child, CNT_TWO, len_maj, wid_child, 1'b1);
    end
  endtask

  function automatic in_item_t make_item(input logic [SYM_W-1:0] sym,
                                         input logic [CNT_W-1:0] cnt,
                                         input logic [PARAM_W-1:0] first,
                                         input logic [PARAM_W-1:0] second,
                                         input logic [DRAW_W-1:0] draw);
    in_item_t it;
    it.symbol_code = sym;
    it.param_count = cnt;
    it.param_first = first;
    it.param_second = second;
    it.random_draw = draw;
    return it;
  endfunction

  // mostly growing symbols with two parameters, the rest noise
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.param_first = $urandom;
    it.param_second = $urandom;
    it.random_draw = DRAW_W'($urandom);
    it.param_count = (pick < 80) ? CNT_TWO : CNT_W'($urandom);
    if (pick < 75)
      it.symbol_code = SYM_A + SYM_W'($urandom_range(0, 2));
    else
      it.symbol_code = SYM_W'($urandom);
    if ($urandom_range(0, 3) == 0) it.param_first = $urandom_range(0, 32'h0004_0000);
    if ($urandom_range(0, 3) == 0) it.param_second = $urandom_range(0, 32'h0002_0000);
    return it;
  endfunction

  task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MAJOR_RATIO:   major_ratio = val[RATIO_W-1:0];
      REG_LATERAL_RATIO: lateral_ratio = val[RATIO_W-1:0];
      REG_BRANCH_ANGLE:  branch_deg = val;
      REG_LATERAL_ANGLE: lateral_deg = val;
      REG_DIVERGENCE:    divergence_deg = val;
      REG_WIDTH_RATIO:   width_ratio = val[RATIO_W-1:0];
      REG_FIRE_PROB:     fire_threshold = val[DRAW_W-1:0];
      default: ;
    endcase
  endtask

  // called at a rising edge; leaves cfg_valid high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] major, input logic [CFG_DATA_W-1:0] lat,
                           input logic [CFG_DATA_W-1:0] branch,
                           input logic [CFG_DATA_W-1:0] lat_deg,
                           input logic [CFG_DATA_W-1:0] div, input logic [CFG_DATA_W-1:0] wr,
                           input logic [CFG_DATA_W-1:0] fire);
    write_reg(REG_MAJOR_RATIO, major);
    write_reg(REG_LATERAL_RATIO, lat);
    write_reg(REG_BRANCH_ANGLE, branch);
    write_reg(REG_LATERAL_ANGLE, lat_deg);
    write_reg(REG_DIVERGENCE, div);
    write_reg(REG_WIDTH_RATIO, wr);
    write_reg(REG_FIRE_PROB, fire);
    cfg_valid <= 1'b0;
  endtask

  // block drained: everything sent, every result back, then a short pause
  task automatic settle();
    while (pending_symbols.size() != 0 || s_tvalid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) add_symbol(random_item());
    settle();
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_hold = 0;
    end else begin
      if (s_tvalid && s_tready) predict_rewrite(in_item_t'(s_tdata[IN_W-1:0]));
      if (!s_tvalid || s_tready) begin
        if (src_hold != 0) begin
          src_hold--;
          s_tvalid <= 1'b0;
        end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
          src_hold = $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else if (pending_symbols.size() != 0) begin
          s_tdata <= {{(IN_TDATA_W - IN_W){1'b0}}, pending_symbols.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = out_item_t'(m_tdata[OUT_W-1:0]);
        if (results_due.size() == 0) begin
          note_mismatch("result with nothing due, symbol", 32'(seen.out_symbol_code), '0);
        end else begin
          due = results_due.pop_front();
          if (seen.out_symbol_code !== due.item.out_symbol_code)
            note_mismatch("symbol", 32'(seen.out_symbol_code), 32'(due.item.out_symbol_code));
          if (seen.out_param_count !== due.item.out_param_count)
            note_mismatch("param count", 32'(seen.out_param_count),
                          32'(due.item.out_param_count));
          if (seen.out_param_first !== due.item.out_param_first)
            note_mismatch("first param", seen.out_param_first, due.item.out_param_first);
          if (seen.out_param_second !== due.item.out_param_second)
            note_mismatch("second param", seen.out_param_second, due.item.out_param_second);
          if (m_tlast !== due.last_of_run)
            note_mismatch("tlast", 32'(m_tlast), 32'(due.last_of_run));
        end
      end
      if (sink_hold != 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_hold = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[monopodial_tree_rewrite] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold edges, missing parameters, non-growing symbols
    src_idle_pct = 20;
    sink_idle_pct = 20;
    add_symbol(make_item(SYM_A, CNT_TWO, 32'h000A_0000, 32'h0001_0000, '0));
    add_symbol(make_item(SYM_B, CNT_TWO, 32'h0003_8000, 32'h0000_C000, 16'h1234));
    add_symbol(make_item(SYM_C, CNT_TWO, 32'h0005_0000, 32'h0000_8000, RST_FIRE_PROB));
    add_symbol(make_item(SYM_A, CNT_TWO, 32'h0005_0000, 32'h0000_8000,
                         RST_FIRE_PROB + 16'd1));
    add_symbol(make_item(SYM_C, CNT_TWO, 32'h0005_0000, 32'h0000_8000, '1));
    add_symbol(make_item(SYM_A, CNT_NONE, 32'h1234_5678, 32'h9ABC_DEF0, '0));
    add_symbol(make_item(SYM_B, CNT_ONE, 32'h1234_5678, 32'h9ABC_DEF0, '0));
    add_symbol(make_item(SYM_C, CNT_THREE, 32'h1234_5678, 32'h9ABC_DEF0, '0));
    add_symbol(make_item(SYM_A, CNT_TWO, '1, '1, '0));
    add_symbol(make_item(SYM_B, CNT_TWO, '0, '0, '0));
    add_symbol(make_item(SYM_FORWARD, CNT_ONE, 32'h0002_0000, '1, '0));
    add_symbol(make_item(SYM_PUSH, CNT_NONE, '1, '1, '0));
    add_symbol(make_item('0, CNT_THREE, '1, '1, '1));
    add_symbol(make_item('1, CNT_TWO, 32'h8000_0001, 32'h7FFF_FFFE, '0));
    add_symbol(make_item(SYM_LOWER_A, CNT_TWO, 32'h0001_0000, 32'h0001_0000, '0));
    add_symbol(make_item(SYM_LOWER_X, CNT_ONE, '1, '1, '0));
    run_random(90);

    // top of every range but divergence (zero), ratio data wider than the register, unused index
    src_idle_pct = 30;
    sink_idle_pct = 30;
    write_reg(REG_UNUSED, '1);
    write_all('1, 25'h0_0001_0000, 25'h1FF_FFFF, 25'h1FF_FFFF, '0, 25'h0_0001_FFFF, '1);
    add_symbol(make_item(SYM_A, CNT_TWO, '1, '1, '1));
    add_symbol(make_item(SYM_B, CNT_TWO, '1, 32'h8000_0000, 16'h8000));
    add_symbol(make_item(SYM_C, CNT_TWO, 32'h0000_0003, 32'h0001_0000, '1));
    run_random(90);

    // everything zero: only a zero draw rewrites
    src_idle_pct = 10;
    sink_idle_pct = 40;
    write_all('0, '0, '0, '0, '0, '0, '0);
    add_symbol(make_item(SYM_A, CNT_TWO, '1, '1, '0));
    add_symbol(make_item(SYM_B, CNT_TWO, '1, '1, 16'd1));
    run_random(90);

    src_idle_pct = 40;
    sink_idle_pct = 10;
    write_all(CFG_DATA_W'($urandom_range(0, 65536)), CFG_DATA_W'($urandom_range(0, 65536)),
              CFG_DATA_W'($urandom_range(0, 23592960)),
              CFG_DATA_W'($urandom_range(0, 23592960)),
              CFG_DATA_W'($urandom_range(0, 23592960)),
              CFG_DATA_W'($urandom_range(0, 65536)), CFG_DATA_W'($urandom_range(0, 65535)));
    run_random(90);

    // closing stretch at full rate on both sides
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_all(CFG_DATA_W'($urandom_range(0, 65536)), CFG_DATA_W'($urandom_range(0, 65536)),
              CFG_DATA_W'($urandom_range(0, 23592960)),
              CFG_DATA_W'($urandom_range(0, 23592960)),
              CFG_DATA_W'($urandom_range(0, 23592960)),
              CFG_DATA_W'($urandom_range(0, 65536)),
              CFG_DATA_W'($urandom_range(32768, 65535)));
    run_random(90);

    if (mismatches == 0) begin
      $display("[monopodial_tree_rewrite] OK");
    end else begin
      $display("[monopodial_tree_rewrite] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/mtr_pkg.sv
hdl/mtr_expand.sv
hdl/monopodial_tree_rewrite.sv
hdl/mtr_checker.sv
tb/monopodial_tree_rewrite_test.sv
